>>> rtl/sfla_pkg.sv
`default_nettype none

package sfla_pkg;

    localparam int CLASS_COUNT_DEF = 8;
    localparam int NODE_COUNT_DEF  = 1024;

    localparam int CLASS_STEP  = 16;
    localparam int BYTES_W     = 16;
    localparam int INDEX_W     = 10;
    localparam int LINK_W      = INDEX_W + 1;
    localparam int CLS_FIELD_W = 4;
    localparam int STATUS_W    = 3;
    localparam int SIZE_CLS_W  = 3;
    localparam int GBYTES_W    = 8;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_HIT       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FALLBACK  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BIG_ALLOC = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_PUSHED    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BIG_FREE  = 3'd4;

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } fsm_state_t;

    typedef struct packed
    {
        logic                   en;
        logic [CLS_FIELD_W-1:0] cls;
        logic [LINK_W-1:0]      value;
    } head_wr_t;

endpackage

`default_nettype wire

>>> rtl/sfla_ram.sv
`default_nettype none

module sfla_ram
#(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/sfla_heads.sv
`default_nettype none

module sfla_heads
#(
    parameter int CLASS_COUNT = 8,
    parameter int CW          = 3
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [CW-1:0]                  rd_cls,
    output logic      [sfla_pkg::LINK_W-1:0]    rd_head,
    input  wire sfla_pkg::head_wr_t             wr
);

    import sfla_pkg::*;

    logic [CLASS_COUNT-1:0] valid_reg;
    logic [INDEX_W-1:0]     index_reg [CLASS_COUNT];
    logic [CW-1:0]          wr_cls;

    assign wr_cls = CW'(wr.cls);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr_cls] <= wr.value[LINK_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            index_reg[wr_cls] <= wr.value[INDEX_W-1:0];
        end
    end

    always_comb
    begin
        if (32'(rd_cls) < CLASS_COUNT)
        begin
            rd_head = {valid_reg[rd_cls], index_reg[rd_cls]};
        end
        else
        begin
            rd_head = '0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/size_class_free_list_allocator.sv
// An accepted request is held in the request registers; its result goes to
// the output registers once the output is free. The input stalls until then,
// as an allocate must read the link memory before its list head is updated.
// Reset: all class lists empty (head valid bits cleared) at once; the link
// memory is not cleared and needs no clearing pass.
`default_nettype none

module size_class_free_list_allocator
#(
    parameter int CLASS_COUNT = sfla_pkg::CLASS_COUNT_DEF,
    parameter int NODE_COUNT  = sfla_pkg::NODE_COUNT_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              command,
    input  wire logic [sfla_pkg::BYTES_W-1:0]      request_bytes,
    input  wire logic [sfla_pkg::INDEX_W-1:0]      block_index,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [sfla_pkg::INDEX_W-1:0]      granted_index,
    output logic      [sfla_pkg::STATUS_W-1:0]     status,
    output logic      [sfla_pkg::SIZE_CLS_W-1:0]   size_class,
    output logic      [sfla_pkg::GBYTES_W-1:0]     granted_bytes
);

    import sfla_pkg::*;

    localparam int CW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int AW = $clog2(NODE_COUNT);
    localparam logic [BYTES_W-1:0] MAX_BYTES = BYTES_W'(CLASS_COUNT * CLASS_STEP);

    function automatic logic [INDEX_W-1:0] wrap_node(input logic [INDEX_W-1:0] v);
        logic [INDEX_W-1:0] r;
        r = v;
        for (int k = 6; k >= 0; k--)
        begin
            if ((NODE_COUNT << k) <= ((1 << INDEX_W) - 1))
            begin
                if (r >= INDEX_W'(NODE_COUNT << k))
                begin
                    r = r - INDEX_W'(NODE_COUNT << k);
                end
            end
        end
        return r;
    endfunction

    fsm_state_t state_reg;
    fsm_state_t state_next;

    logic                   accept;
    logic                   commit;
    logic                   out_free;

    logic [BYTES_W-1:0]     bytes_m1;
    logic [CLS_FIELD_W-1:0] cls_in;
    logic                   fits_in;
    logic [LINK_W-1:0]      head_rd;

    logic                   cmd_reg;
    logic                   fits_reg;
    logic [CLS_FIELD_W-1:0] cls_reg;
    logic [INDEX_W-1:0]     blk_reg;
    logic [LINK_W-1:0]      head_reg;

    logic                   ram_re;
    logic                   ram_we;
    logic [LINK_W-1:0]      ram_rdata;
    head_wr_t               head_wr;

    logic                   out_valid_reg;
    logic [INDEX_W-1:0]     granted_index_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [SIZE_CLS_W-1:0]  size_class_reg;
    logic [GBYTES_W-1:0]    granted_bytes_reg;

    logic [INDEX_W-1:0]     res_index;
    logic [STATUS_W-1:0]    res_status;
    logic [CLS_FIELD_W-1:0] cls_plus1;

    assign bytes_m1 = request_bytes - BYTES_W'(1);
    assign cls_in   = (request_bytes == '0) ? '0 : bytes_m1[CLS_FIELD_W+3:4];
    assign fits_in  = (request_bytes <= MAX_BYTES);
    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;

    sfla_heads
    #(
        .CLASS_COUNT (CLASS_COUNT),
        .CW          (CW)
    )
    u_heads
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_cls  (CW'(cls_in)),
        .rd_head (head_rd),
        .wr      (head_wr)
    );

    sfla_ram
    #(
        .WIDTH (LINK_W),
        .DEPTH (NODE_COUNT)
    )
    u_links
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'({{AW{1'b0}}, blk_reg})),
        .wdata (head_reg),
        .re    (ram_re),
        .raddr (AW'({{AW{1'b0}}, head_rd[INDEX_W-1:0]})),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_EXEC:
            begin
                commit = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // read the link of the head block while the request is captured
    assign ram_re = accept && fits_in && (command == CMD_ALLOC) && head_rd[LINK_W-1];
    assign ram_we = commit && fits_reg && (cmd_reg == CMD_FREE);

    always_comb
    begin
        head_wr.en    = 1'b0;
        head_wr.cls   = cls_reg;
        head_wr.value = ram_rdata;
        res_index     = '0;
        if (!fits_reg)
        begin
            res_status = (cmd_reg == CMD_FREE) ? STATUS_BIG_FREE : STATUS_BIG_ALLOC;
        end
        else if (cmd_reg == CMD_FREE)
        begin
            head_wr.en    = commit;
            head_wr.value = {1'b1, blk_reg};
            res_status    = STATUS_PUSHED;
        end
        else if (head_reg[LINK_W-1])
        begin
            head_wr.en = commit;
            res_index  = head_reg[INDEX_W-1:0];
            res_status = STATUS_HIT;
        end
        else
        begin
            res_status = STATUS_FALLBACK;
        end
    end

    assign cls_plus1 = cls_reg + CLS_FIELD_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            fits_reg <= fits_in;
            cls_reg  <= cls_in;
            blk_reg  <= wrap_node(block_index);
            head_reg <= head_rd;
        end
        if (commit)
        begin
            granted_index_reg <= res_index;
            status_reg        <= res_status;
            size_class_reg    <= fits_reg ? cls_reg[SIZE_CLS_W-1:0] : '0;
            granted_bytes_reg <= fits_reg ? {cls_plus1, 4'b0000} : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_index = granted_index_reg;
    assign status        = status_reg;
    assign size_class    = size_class_reg;
    assign granted_bytes = granted_bytes_reg;

endmodule

`default_nettype wire

>>> tb/size_class_free_list_allocator_tb.sv
`timescale 1ns / 100ps

module size_class_free_list_allocator_tb;

    import sfla_pkg::*;

    localparam int CLASS_TOTAL  = 8;
    localparam int NODE_TOTAL   = 1024;
    localparam int CLASS_LIMIT  = CLASS_TOTAL * CLASS_STEP;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 800;
    localparam int HOLD_LEN     = 120;
    localparam int DRAIN_AT     = 1200;
    localparam int QUIET_FROM   = 2000;
    localparam int QUIET_TO     = 2800;
    localparam int IDLE_PCT     = 19;

    typedef struct packed
    {
        logic               command;
        logic [BYTES_W-1:0] bytes;
        logic [INDEX_W-1:0] index;
    } request_t;

    typedef struct packed
    {
        logic [INDEX_W-1:0]    index;
        logic [STATUS_W-1:0]   status;
        logic [SIZE_CLS_W-1:0] size_class;
        logic [GBYTES_W-1:0]   granted_bytes;
    } grant_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic                  command       = CMD_ALLOC;
    logic [BYTES_W-1:0]    request_bytes = '0;
    logic [INDEX_W-1:0]    block_index   = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [INDEX_W-1:0]    granted_index;
    logic [STATUS_W-1:0]   status;
    logic [SIZE_CLS_W-1:0] size_class;
    logic [GBYTES_W-1:0]   granted_bytes;

    logic [LINK_W-1:0] list_heads [CLASS_TOTAL];
    logic [LINK_W-1:0] link_words [NODE_TOTAL];

    request_t pending_requests[$];
    grant_t   expected_grants[$];
    request_t next_request;
    grant_t   want;

    int   cycle_count    = 0;
    int   hold_left      = 0;
    int   accepted_beats = 0;
    int   results_seen   = 0;
    int   fault_count    = 0;
    logic request_beat;
    logic draining       = 1'b0;
    logic quiet_window;

    assign quiet_window = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    size_class_free_list_allocator u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .request_bytes (request_bytes),
        .block_index   (block_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted_index (granted_index),
        .status        (status),
        .size_class    (size_class),
        .granted_bytes (granted_bytes)
    );

    always #2 clk = ~clk;

    function automatic grant_t allocate_or_free(logic cmd, logic [BYTES_W-1:0] bytes,
                                                logic [INDEX_W-1:0] index);
        grant_t           g;
        int               cls;
        logic [LINK_W-1:0] head;
        g   = '0;
        cls = (bytes == 0) ? 0 : (int'(bytes) - 1) / CLASS_STEP;
        if (int'(bytes) > CLASS_LIMIT)
        begin
            g.status = (cmd == CMD_FREE) ? STATUS_BIG_FREE : STATUS_BIG_ALLOC;
            return g;
        end
        head            = list_heads[cls];
        g.size_class    = SIZE_CLS_W'(cls);
        g.granted_bytes = GBYTES_W'((cls + 1) * CLASS_STEP);
        if (cmd == CMD_FREE)
        begin
            link_words[index] = head;
            list_heads[cls]   = {1'b1, index};
            g.status          = STATUS_PUSHED;
        end
        else if (head[INDEX_W])
        begin
            g.index         = head[INDEX_W-1:0];
            list_heads[cls] = link_words[head[INDEX_W-1:0]];
            g.status        = STATUS_HIT;
        end
        else
        begin
            g.status = STATUS_FALLBACK;
        end
        return g;
    endfunction

    task automatic queue_request(logic cmd, int bytes, int index);
        pending_requests.push_back('{cmd, BYTES_W'(bytes), INDEX_W'(index)});
    endtask

    task automatic report_fault(string what, grant_t exp_g, grant_t got_g);
        fault_count++;
        if (fault_count <= 10)
            $display({"%0t %s: expected idx=%0d st=%0d cls=%0d bytes=%0d,",
                      " got idx=%0d st=%0d cls=%0d bytes=%0d"},
                     $realtime, what, exp_g.index, exp_g.status, exp_g.size_class,
                     exp_g.granted_bytes, got_g.index, got_g.status, got_g.size_class,
                     got_g.granted_bytes);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("size_class_free_list_allocator_tb: errors");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (cycle_count == HOLD_AT)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            command       <= CMD_ALLOC;
            request_bytes <= '0;
            block_index   <= '0;
        end
        else
        begin
            request_beat = in_valid && !in_stall;
            if (request_beat)
            begin
                expected_grants.push_back(allocate_or_free(command, request_bytes, block_index));
                accepted_beats++;
                if (accepted_beats == DRAIN_AT)
                    draining = 1'b1;
            end
            if (draining && results_seen == accepted_beats)
                draining = 1'b0;
            if (!in_valid || request_beat)
            begin
                if (pending_requests.size() != 0 && !draining &&
                    (quiet_window || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_request = pending_requests.pop_front();
                    in_valid      <= 1'b1;
                    command       <= next_request.command;
                    request_bytes <= next_request.bytes;
                    block_index   <= next_request.index;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_grants.size() == 0)
                begin
                    report_fault("unexpected beat", '0,
                                 '{granted_index, status, size_class, granted_bytes});
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (granted_index !== want.index || status !== want.status ||
                        size_class !== want.size_class || granted_bytes !== want.granted_bytes)
                        report_fault("mismatch", want,
                                     '{granted_index, status, size_class, granted_bytes});
                end
            end
            out_stall <= (hold_left != 0) ||
                         (!quiet_window && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin
        int free_pct;
        int roll;
        int bytes;

        foreach (list_heads[c])
            list_heads[c] = '0;
        foreach (link_words[n])
            link_words[n] = '0;

        queue_request(CMD_ALLOC, 0, 0);
        queue_request(CMD_ALLOC, 128, 1023);
        queue_request(CMD_ALLOC, 129, 0);
        queue_request(CMD_ALLOC, 65535, 1023);
        queue_request(CMD_FREE, 129, 5);
        queue_request(CMD_FREE, 65535, 1023);
        queue_request(CMD_FREE, 0, 0);
        queue_request(CMD_FREE, 16, 1023);
        queue_request(CMD_FREE, 17, 512);
        queue_request(CMD_ALLOC, 16, 0);
        queue_request(CMD_ALLOC, 1, 0);
        queue_request(CMD_ALLOC, 0, 0);
        queue_request(CMD_ALLOC, 32, 0);
        queue_request(CMD_ALLOC, 33, 0);
        queue_request(CMD_FREE, 50, 7);
        queue_request(CMD_FREE, 50, 7);
        queue_request(CMD_FREE, 100, 7);
        queue_request(CMD_ALLOC, 50, 0);
        queue_request(CMD_ALLOC, 50, 0);
        queue_request(CMD_ALLOC, 100, 0);
        queue_request(CMD_FREE, 128, 341);
        queue_request(CMD_FREE, 113, 682);
        queue_request(CMD_ALLOC, 112, 0);
        queue_request(CMD_ALLOC, 128, 0);
        queue_request(CMD_ALLOC, 113, 0);

        free_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                free_pct = $urandom_range(25, 75);
            roll = $urandom_range(0, 99);
            if (roll < 8)
                bytes = $urandom_range(CLASS_LIMIT + 1, 65535);
            else if (roll < 10)
                bytes = $urandom_range(0, 65535);
            else
                bytes = $urandom_range(0, CLASS_LIMIT);
            queue_request(($urandom_range(0, 99) < free_pct) ? CMD_FREE : CMD_ALLOC,
                          bytes, $urandom_range(0, NODE_TOTAL - 1));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || in_valid || results_seen != accepted_beats)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (fault_count == 0)
            $display("size_class_free_list_allocator_tb: clean");
        else
            $display("size_class_free_list_allocator_tb: errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/sfla_pkg.sv
rtl/sfla_ram.sv
rtl/sfla_heads.sv
rtl/size_class_free_list_allocator.sv
tb/size_class_free_list_allocator_tb.sv
